FILE: src/temporal_earliest_arrival_bfs_defines.svh
// Assertion helpers shared by the RTL.
`ifndef TEMPORAL_EARLIEST_ARRIVAL_BFS_DEFINES_SVH
`define TEMPORAL_EARLIEST_ARRIVAL_BFS_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define TEA_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TEA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/tea_pkg.sv
`default_nettype none

package tea_pkg;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 12;
    localparam int VTX_W   = 8;
    localparam int TIME_W  = 30;
    localparam int ARR_W   = 31;
    localparam int OFF_W   = 13;
    localparam int EDGE_W  = 10;
    localparam int VC_W    = 9;
    localparam int CC_W    = 11;
    localparam int ITEM_W  = 157;
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 40;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD_CONN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_OFF  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_EDGE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

    localparam logic RES_QUERY = 1'b0;
    localparam logic RES_READ  = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_CONN_COUNT   = 1'b1;

    localparam logic [VC_W-1:0]  VC_RESET  = 9'd256;
    localparam logic [CC_W-1:0]  CC_RESET  = 11'd0;
    localparam logic [ARR_W-1:0] UNREACHED = 31'h7FFF_FFFF;

    // Input item as packed in s_tdata, first field in the highest bits.
    typedef struct packed {
        logic [VTX_W-1:0]  read_vertex;
        logic [TIME_W-1:0] ready_time;
        logic [VTX_W-1:0]  source_vertex;
        logic [EDGE_W-1:0] edge_target;
        logic [OFF_W-1:0]  offset_value;
        logic [TIME_W-1:0] travel_time;
        logic [TIME_W-1:0] depart_time;
        logic [VTX_W-1:0]  to_vertex;
        logic [VTX_W-1:0]  from_vertex;
        logic [IDX_W-1:0]  entry_index;
    } item_t;

    // One connection table entry.
    typedef struct packed {
        logic [VTX_W-1:0]  from_vertex;
        logic [VTX_W-1:0]  to_vertex;
        logic [TIME_W-1:0] depart_time;
        logic [TIME_W-1:0] travel_time;
    } conn_t;

endpackage

`default_nettype wire

FILE: src/tea_ram.sv
`default_nettype none

module tea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/temporal_earliest_arrival_bfs.sv
// Channel   | Ports                        | Carries
// ----------+------------------------------+---------------------------------------------
// input     | s_tvalid s_tready s_tdata    | loads, queries and arrival reads (kind in
//           | s_tuser                      | s_tuser)
// result    | m_tvalid m_tready m_tdata    | query finished / arrival reply (kind in
//           | m_tuser                      | m_tuser)
// config    | psel penable pwrite paddr    | vertex_count at 0, connection_count at 4
//           | pwdata prdata pready         |
//
// Loads are written as they are taken, leaving the block ready. A read goes through the
// read and reply states. A query first sweeps addresses below max(MAX_VERTICES,
// MAX_CONNECTIONS), clearing the visited memory and the arrival entries below the vertex
// count, then scans the connection table once per seed found (plus once), then walks the
// queue, reading each dequeued connection and, if it improves its end vertex, its
// successors. All memories are simple dual-port. After reset a sweep clears all arrival
// entries before the first item is taken. The block holds s_tready low while it works; a
// result that waits on m_tready stalls only the next query or read.
`default_nettype none

`include "temporal_earliest_arrival_bfs_defines.svh"

module temporal_earliest_arrival_bfs #(
    parameter int MAX_VERTICES     = 256,
    parameter int MAX_CONNECTIONS  = 1024,
    parameter int MAX_DEPENDENCIES = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index, from_vertex, to_vertex, depart_time, travel_time, offset_value,
    // edge_target, source_vertex, ready_time, read_vertex (lowest bit up), zero padded
    input  wire logic [tea_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [tea_pkg::KIND_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // vertex_id, arrival_time, reached (lowest bit up)
    output logic      [tea_pkg::M_TDATA_W-1:0]  m_tdata,
    // result_kind
    output logic                                m_tuser,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tea_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [tea_pkg::PDATA_W-1:0]    pwdata,
    output logic      [tea_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_CONNECTIONS);
    localparam int DW    = $clog2(MAX_DEPENDENCIES);
    localparam int OW    = $clog2(MAX_CONNECTIONS + 1);
    localparam int NCW   = CW + 1;
    localparam int NVW   = VW + 1;
    localparam int SWEEP = (MAX_VERTICES > MAX_CONNECTIONS) ? MAX_VERTICES : MAX_CONNECTIONS;
    localparam int SW    = $clog2(SWEEP) + 1;
    localparam int CONN_W = $bits(tea_pkg::conn_t);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_SRC      = 4'd2;
    localparam logic [3:0] ST_SCAN_RD  = 4'd3;
    localparam logic [3:0] ST_SCAN_CHK = 4'd4;
    localparam logic [3:0] ST_SEED     = 4'd5;
    localparam logic [3:0] ST_POP      = 4'd6;
    localparam logic [3:0] ST_CONN     = 4'd7;
    localparam logic [3:0] ST_DST      = 4'd8;
    localparam logic [3:0] ST_CMP      = 4'd9;
    localparam logic [3:0] ST_HI       = 4'd10;
    localparam logic [3:0] ST_TGT      = 4'd11;
    localparam logic [3:0] ST_VIS      = 4'd12;
    localparam logic [3:0] ST_MARK     = 4'd13;
    localparam logic [3:0] ST_RD       = 4'd14;
    localparam logic [3:0] ST_RESP     = 4'd15;

    tea_pkg::item_t item;
    tea_pkg::conn_t conn_wdata, conn_rd;
    logic           in_acc;

    // Control and configuration.
    logic [3:0]                state_reg, state_next;
    logic                      init_reg, init_next;
    logic [SW-1:0]             sweep_reg, sweep_next;
    logic [tea_pkg::VC_W-1:0]  vc_reg;
    logic [tea_pkg::CC_W-1:0]  cc_reg;
    logic [NCW-1:0]            head_reg, head_next, tail_reg, tail_next;
    logic [NCW-1:0]            scan_reg, scan_next;
    logic                      have_prev_reg, have_prev_next, found_reg, found_next;
    logic                      m_valid_reg, m_valid_next;

    // Working values.
    logic [tea_pkg::VTX_W-1:0]  src_reg, src_next, rv_reg, rv_next;
    logic [tea_pkg::TIME_W-1:0] ready_reg, ready_next;
    logic                       rkind_reg, rkind_next;
    logic [tea_pkg::TIME_W-1:0] prev_d_reg, prev_d_next, best_d_reg, best_d_next;
    logic [CW-1:0]              prev_i_reg, prev_i_next, best_i_reg, best_i_next;
    logic [CW-1:0]              cur_c_reg, cur_c_next, s_reg, s_next;
    logic [tea_pkg::VTX_W-1:0]  dst_reg, dst_next;
    logic [tea_pkg::ARR_W-1:0]  t_reg, t_next;
    logic [tea_pkg::OFF_W-1:0]  k_reg, k_next, hi_reg, hi_next;
    logic [tea_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    // Memory ports.
    logic                       conn_we, off_we, tgt_we, arr_we, vis_we, fifo_we;
    logic [CW-1:0]              conn_waddr, conn_raddr, vis_waddr, vis_raddr;
    logic [CW-1:0]              fifo_waddr, fifo_raddr, fifo_wdata, fifo_rdata;
    logic [CONN_W-1:0]          conn_rdata;
    logic [OW-1:0]              off_waddr, off_raddr;
    logic [tea_pkg::OFF_W-1:0]  off_rdata;
    logic [DW-1:0]              tgt_waddr, tgt_raddr;
    logic [tea_pkg::EDGE_W-1:0] tgt_rdata;
    logic [VW-1:0]              arr_waddr, arr_raddr;
    logic [tea_pkg::ARR_W-1:0]  arr_wdata, arr_rdata;
    logic                       vis_wdata, vis_rdata;

    logic [NVW-1:0] nv;
    logic [NCW-1:0] nc;
    logic           cfg_we, cand, better, unr;

    assign item    = tea_pkg::item_t'(s_tdata[tea_pkg::ITEM_W-1:0]);
    assign conn_rd = tea_pkg::conn_t'(conn_rdata);
    assign in_acc  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Effective counts saturate at the storage sizes.
    assign nv = (32'(vc_reg) > 32'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : NVW'(vc_reg);
    assign nc = (32'(cc_reg) > 32'(MAX_CONNECTIONS)) ? NCW'(MAX_CONNECTIONS) : NCW'(cc_reg);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == tea_pkg::REG_CONN_COUNT) ? 32'(cc_reg) : 32'(vc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= tea_pkg::VC_RESET;
            cc_reg <= tea_pkg::CC_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == tea_pkg::REG_CONN_COUNT) begin
                cc_reg <= pwdata[tea_pkg::CC_W-1:0];
            end else begin
                vc_reg <= pwdata[tea_pkg::VC_W-1:0];
            end
        end
    end

    // Seed selection: the next seed is the best connection that orders after the last
    // one taken, where later departures come first and ties go to the lower index.
    assign cand = (conn_rd.from_vertex == src_reg) && (conn_rd.depart_time >= ready_reg)
        && (!have_prev_reg || (conn_rd.depart_time < prev_d_reg)
            || ((conn_rd.depart_time == prev_d_reg) && (CW'(scan_reg) > prev_i_reg)));
    assign better = !found_reg || (conn_rd.depart_time > best_d_reg);

    // Load writes happen straight from the input item.
    assign conn_wdata = '{from_vertex: item.from_vertex, to_vertex: item.to_vertex,
                          depart_time: item.depart_time, travel_time: item.travel_time};
    assign conn_we    = in_acc && (s_tuser == tea_pkg::KIND_LOAD_CONN)
                        && (32'(item.entry_index) < 32'(MAX_CONNECTIONS));
    assign conn_waddr = CW'(item.entry_index);
    assign off_we     = in_acc && (s_tuser == tea_pkg::KIND_LOAD_OFF)
                        && (32'(item.entry_index) <= 32'(MAX_CONNECTIONS));
    assign off_waddr  = OW'(item.entry_index);
    assign tgt_we     = in_acc && (s_tuser == tea_pkg::KIND_LOAD_EDGE)
                        && (32'(item.entry_index) < 32'(MAX_DEPENDENCIES));
    assign tgt_waddr  = DW'(item.entry_index);

    // The reply is unreached when the vertex has no storage or holds the marker.
    assign unr = (32'(rv_reg) >= 32'(MAX_VERTICES)) || (arr_rdata == tea_pkg::UNREACHED);

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        sweep_next     = sweep_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        have_prev_next = have_prev_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        src_next       = src_reg;
        rv_next        = rv_reg;
        ready_next     = ready_reg;
        rkind_next     = rkind_reg;
        prev_d_next    = prev_d_reg;
        prev_i_next    = prev_i_reg;
        best_d_next    = best_d_reg;
        best_i_next    = best_i_reg;
        cur_c_next     = cur_c_reg;
        s_next         = s_reg;
        dst_next       = dst_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        hi_next        = hi_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        conn_raddr = '0;
        off_raddr  = '0;
        tgt_raddr  = '0;
        arr_we     = 1'b0;
        arr_waddr  = '0;
        arr_wdata  = tea_pkg::UNREACHED;
        arr_raddr  = '0;
        vis_we     = 1'b0;
        vis_waddr  = '0;
        vis_wdata  = 1'b0;
        vis_raddr  = '0;
        fifo_we    = 1'b0;
        fifo_waddr = '0;
        fifo_wdata = '0;
        fifo_raddr = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_tuser == tea_pkg::KIND_QUERY)) begin
                    src_next   = item.source_vertex;
                    ready_next = item.ready_time;
                    init_next  = 1'b0;
                    sweep_next = '0;
                    state_next = ST_CLEAR;
                end else if (in_acc && (s_tuser == tea_pkg::KIND_READ)) begin
                    rv_next    = item.read_vertex;
                    rkind_next = tea_pkg::RES_READ;
                    state_next = ST_RD;
                end
            end
            ST_CLEAR: begin
                arr_waddr = VW'(sweep_reg);
                arr_we    = init_reg ? (32'(sweep_reg) < 32'(MAX_VERTICES))
                                     : (32'(sweep_reg) < 32'(nv));
                vis_waddr = CW'(sweep_reg);
                vis_we    = (32'(sweep_reg) < 32'(MAX_CONNECTIONS));
                sweep_next = SW'(sweep_reg + 1'b1);
                if (sweep_reg == SW'(SWEEP - 1)) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_SRC;
                end
            end
            ST_SRC: begin
                arr_we         = (32'(src_reg) < 32'(MAX_VERTICES));
                arr_waddr      = VW'(src_reg);
                arr_wdata      = {1'b0, ready_reg};
                head_next      = '0;
                tail_next      = '0;
                scan_next      = '0;
                have_prev_next = 1'b0;
                found_next     = 1'b0;
                state_next     = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                conn_raddr = CW'(scan_reg);
                state_next = (scan_reg < nc) ? ST_SCAN_CHK : ST_SEED;
            end
            ST_SCAN_CHK: begin
                if (cand && better) begin
                    found_next  = 1'b1;
                    best_d_next = conn_rd.depart_time;
                    best_i_next = CW'(scan_reg);
                end
                scan_next  = NCW'(scan_reg + 1'b1);
                state_next = ST_SCAN_RD;
            end
            ST_SEED: begin
                if (found_reg) begin
                    fifo_we        = 1'b1;
                    fifo_waddr     = CW'(tail_reg);
                    fifo_wdata     = best_i_reg;
                    vis_we         = 1'b1;
                    vis_waddr      = best_i_reg;
                    vis_wdata      = 1'b1;
                    tail_next      = NCW'(tail_reg + 1'b1);
                    prev_d_next    = best_d_reg;
                    prev_i_next    = best_i_reg;
                    have_prev_next = 1'b1;
                    found_next     = 1'b0;
                    scan_next      = '0;
                    state_next     = ST_SCAN_RD;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (head_reg == tail_reg) begin
                    rv_next    = src_reg;
                    rkind_next = tea_pkg::RES_QUERY;
                    state_next = ST_RD;
                end else begin
                    fifo_raddr = CW'(head_reg);
                    head_next  = NCW'(head_reg + 1'b1);
                    state_next = ST_CONN;
                end
            end
            ST_CONN: begin
                cur_c_next = fifo_rdata;
                conn_raddr = fifo_rdata;
                state_next = ST_DST;
            end
            ST_DST: begin
                dst_next   = conn_rd.to_vertex;
                t_next     = {1'b0, conn_rd.depart_time} + {1'b0, conn_rd.travel_time};
                arr_raddr  = VW'(conn_rd.to_vertex);
                off_raddr  = OW'(cur_c_reg);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // A connection that improves its end vertex expands its successors.
                if ((32'(dst_reg) < 32'(MAX_VERTICES)) && (arr_rdata > t_reg)) begin
                    arr_we     = 1'b1;
                    arr_waddr  = VW'(dst_reg);
                    arr_wdata  = t_reg;
                    k_next     = off_rdata;
                    off_raddr  = OW'(OW'(cur_c_reg) + 1'b1);
                    state_next = ST_HI;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_HI: begin
                hi_next = (32'(off_rdata) > 32'(MAX_DEPENDENCIES))
                          ? tea_pkg::OFF_W'(MAX_DEPENDENCIES) : off_rdata;
                state_next = ST_TGT;
            end
            ST_TGT: begin
                if (k_reg < hi_reg) begin
                    tgt_raddr  = DW'(k_reg);
                    k_next     = tea_pkg::OFF_W'(k_reg + 1'b1);
                    state_next = ST_VIS;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_VIS: begin
                if (32'(tgt_rdata) < 32'(nc)) begin
                    vis_raddr  = CW'(tgt_rdata);
                    s_next     = CW'(tgt_rdata);
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_TGT;
                end
            end
            ST_MARK: begin
                if (!vis_rdata) begin
                    vis_we     = 1'b1;
                    vis_waddr  = s_reg;
                    vis_wdata  = 1'b1;
                    fifo_we    = 1'b1;
                    fifo_waddr = CW'(tail_reg);
                    fifo_wdata = s_reg;
                    tail_next  = NCW'(tail_reg + 1'b1);
                end
                state_next = ST_TGT;
            end
            ST_RD: begin
                arr_raddr  = VW'(rv_reg);
                state_next = ST_RESP;
            end
            ST_RESP: begin
                arr_raddr = VW'(rv_reg);
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = rkind_reg;
                    m_data_next  = {!unr, (unr ? '0 : arr_rdata), rv_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_reg      <= '0;
            have_prev_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            sweep_reg     <= sweep_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_reg      <= scan_next;
            have_prev_reg <= have_prev_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        rv_reg     <= rv_next;
        ready_reg  <= ready_next;
        rkind_reg  <= rkind_next;
        prev_d_reg <= prev_d_next;
        prev_i_reg <= prev_i_next;
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        cur_c_reg  <= cur_c_next;
        s_reg      <= s_next;
        dst_reg    <= dst_next;
        t_reg      <= t_next;
        k_reg      <= k_next;
        hi_reg     <= hi_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    tea_ram #(.WIDTH(CONN_W), .DEPTH(MAX_CONNECTIONS)) u_conn_ram (
        .aclk(aclk), .we(conn_we), .waddr(conn_waddr), .wdata(conn_wdata),
        .raddr(conn_raddr), .rdata(conn_rdata)
    );

    tea_ram #(.WIDTH(tea_pkg::OFF_W), .DEPTH(MAX_CONNECTIONS + 1)) u_off_ram (
        .aclk(aclk), .we(off_we), .waddr(off_waddr), .wdata(item.offset_value),
        .raddr(off_raddr), .rdata(off_rdata)
    );

    tea_ram #(.WIDTH(tea_pkg::EDGE_W), .DEPTH(MAX_DEPENDENCIES)) u_tgt_ram (
        .aclk(aclk), .we(tgt_we), .waddr(tgt_waddr), .wdata(item.edge_target),
        .raddr(tgt_raddr), .rdata(tgt_rdata)
    );

    tea_ram #(.WIDTH(tea_pkg::ARR_W), .DEPTH(MAX_VERTICES)) u_arr_ram (
        .aclk(aclk), .we(arr_we), .waddr(arr_waddr), .wdata(arr_wdata),
        .raddr(arr_raddr), .rdata(arr_rdata)
    );

    tea_ram #(.WIDTH(1), .DEPTH(MAX_CONNECTIONS)) u_vis_ram (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    tea_ram #(.WIDTH(CW), .DEPTH(MAX_CONNECTIONS)) u_fifo_ram (
        .aclk(aclk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
        .raddr(fifo_raddr), .rdata(fifo_rdata)
    );

    // The queue never reads past what was written, and never holds more than one
    // entry per connection.
    `TEA_ASSERT_ALWAYS(a_head_le_tail, aclk, aresetn, head_reg <= tail_reg, "queue head passed tail")
    `TEA_ASSERT_ALWAYS(a_tail_bound, aclk, aresetn, 32'(tail_reg) <= 32'(MAX_CONNECTIONS), "queue overflow")
    // A result appears only out of the reply state.
    `TEA_ASSERT_IMPLIES(a_valid_src, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_RESP, "result without reply")

endmodule

`default_nettype wire

FILE: verif/tea_checker.sv
`timescale 1ns / 1ps

// Watches the input, result and register ports of the earliest-arrival
// search block, keeps its own copy of the tables and arrival times, and
// compares every reply with the oldest prediction.
module tea_checker
    import tea_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [KIND_W-1:0]    s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    input  wire logic                 pready,
    output int                        mismatches,
    output int                        replies_pending
);

    typedef struct packed {
        logic             result_kind;
        logic [VTX_W-1:0] vertex_id;
        logic [ARR_W-1:0] arrival_time;
        logic             reached;
    } reply_t;

    logic [VTX_W-1:0]  conn_src   [1024];
    logic [VTX_W-1:0]  conn_dst   [1024];
    logic [TIME_W-1:0] conn_dep   [1024];
    logic [TIME_W-1:0] conn_trav  [1024];
    logic [OFF_W-1:0]  succ_first [1025];
    logic [EDGE_W-1:0] succ_conn  [4096];
    logic [ARR_W-1:0]  arrival    [256];
    bit                visited    [1024];
    logic [VC_W-1:0]   vertex_limit;
    logic [CC_W-1:0]   conn_limit;
    reply_t            replies_due[$];

    // Earliest-arrival walk: seeds ordered by latest departure, lowest
    // index first among equal departures, then a first-in first-out sweep.
    function automatic void run_search(logic [VTX_W-1:0] src, logic [TIME_W-1:0] ready);
        int nv;
        int nc;
        int pos;
        int head;
        int c;
        int lo;
        int hi;
        int s;
        logic [31:0] reach;
        int seeds[$];
        int walk[$];
        nv = (vertex_limit > 256) ? 256 : int'(vertex_limit);
        nc = (conn_limit > 1024) ? 1024 : int'(conn_limit);
        for (int i = 0; i < nv; i++) arrival[i] = UNREACHED;
        for (int i = 0; i < 1024; i++) visited[i] = 1'b0;
        for (int i = 0; i < nc; i++) begin
            if (conn_src[i] != src || conn_dep[i] < ready) continue;
            pos = seeds.size();
            while (pos > 0 && conn_dep[seeds[pos-1]] < conn_dep[i]) pos--;
            seeds.insert(pos, i);
        end
        arrival[src] = {1'b0, ready};
        foreach (seeds[i]) begin
            walk = {walk, seeds[i]};
            visited[seeds[i]] = 1'b1;
        end
        head = 0;
        while (head < walk.size()) begin
            c = walk[head];
            head++;
            reach = {2'b00, conn_dep[c]} + {2'b00, conn_trav[c]};
            if (!({1'b0, arrival[conn_dst[c]]} > reach)) continue;
            arrival[conn_dst[c]] = reach[ARR_W-1:0];
            lo = succ_first[c];
            hi = succ_first[c+1];
            if (hi > 4096) hi = 4096;
            for (int k = lo; k < hi; k++) begin
                s = succ_conn[k];
                if (s >= nc || visited[s]) continue;
                visited[s] = 1'b1;
                if (walk.size() < 1024) walk = {walk, s};
            end
        end
    endfunction

    function automatic reply_t make_reply(logic kind, logic [VTX_W-1:0] v);
        reply_t r;
        r.result_kind  = kind;
        r.vertex_id    = v;
        r.reached      = (arrival[v] != UNREACHED);
        r.arrival_time = r.reached ? arrival[v] : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        item_t  it;
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            vertex_limit = VC_RESET;
            conn_limit   = CC_RESET;
            for (int i = 0; i < 256; i++) arrival[i] = UNREACHED;
            replies_due.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_VERTEX_COUNT) vertex_limit = pwdata[VC_W-1:0];
                else conn_limit = pwdata[CC_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                it = item_t'(s_tdata[ITEM_W-1:0]);
                case (s_tuser)
                    KIND_LOAD_CONN: if (it.entry_index < 1024) begin
                        conn_src[it.entry_index]  = it.from_vertex;
                        conn_dst[it.entry_index]  = it.to_vertex;
                        conn_dep[it.entry_index]  = it.depart_time;
                        conn_trav[it.entry_index] = it.travel_time;
                    end
                    KIND_LOAD_OFF: if (it.entry_index <= 1024)
                        succ_first[it.entry_index] = it.offset_value;
                    KIND_LOAD_EDGE: succ_conn[it.entry_index] = it.edge_target;
                    KIND_QUERY: begin
                        run_search(it.source_vertex, it.ready_time);
                        replies_due = {replies_due, make_reply(RES_QUERY, it.source_vertex)};
                    end
                    KIND_READ: replies_due = {replies_due, make_reply(RES_READ, it.read_vertex)};
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.result_kind  = m_tuser;
                got.vertex_id    = m_tdata[7:0];
                got.arrival_time = m_tdata[38:8];
                got.reached      = m_tdata[39];
                if (replies_due.size() == 0) begin
                    $error("reply with nothing expected: kind %0d vertex %0d",
                           got.result_kind, got.vertex_id);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, got.result_kind);
                        mismatches++;
                    end
                    if (got.vertex_id !== want.vertex_id) begin
                        $error("vertex_id: expected %0d, got %0d",
                               want.vertex_id, got.vertex_id);
                        mismatches++;
                    end
                    if (got.arrival_time !== want.arrival_time) begin
                        $error("arrival_time: expected %0d, got %0d",
                               want.arrival_time, got.arrival_time);
                        mismatches++;
                    end
                    if (got.reached !== want.reached) begin
                        $error("reached: expected %0d, got %0d", want.reached, got.reached);
                        mismatches++;
                    end
                end
            end
        end
        replies_pending = replies_due.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Top of the earliest-arrival search testbench. It resets the block, builds
// a series of small temporal graphs through the input channel, runs queries
// and arrival reads against them, and leaves all checking to tea_checker.
module testbench;
    import tea_pkg::*;

    typedef logic [KIND_W-1:0] KIND_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   mismatches;
    int                   replies_pending;

    // Sender bookkeeping: items left in the current burst, plus tallies for
    // the closing summary.
    int burst_left;
    int items_sent;
    int queries_sent;
    int reads_sent;
    int graphs_built;

    temporal_earliest_arrival_bfs u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tea_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .replies_pending(replies_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hard stop well beyond the slowest legal run. Every query first sweeps
    // its memories clear.
    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

    // The receiver cycles through stall patterns of its own. Once, early in
    // the run, it refuses results for a long stretch while the sender keeps
    // offering items, so that a finished reply blocks the next query or read.
    initial begin
        int cycle;
        int mode;
        int hold;
        m_tready = 1'b0;
        cycle = 0;
        mode = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            cycle++;
            if (cycle == 30000) hold = 4000;
            if (cycle % 300 == 0) mode = $urandom_range(0, 2);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // An item with every field random; callers override the fields that
    // matter for its kind, so the ignored fields still see both bit values.
    function automatic item_t any_item();
        item_t it;
        it.entry_index   = IDX_W'($urandom);
        it.from_vertex   = VTX_W'($urandom);
        it.to_vertex     = VTX_W'($urandom);
        it.depart_time   = TIME_W'($urandom);
        it.travel_time   = TIME_W'($urandom);
        it.offset_value  = OFF_W'($urandom);
        it.edge_target   = EDGE_W'($urandom);
        it.source_vertex = VTX_W'($urandom);
        it.ready_time    = TIME_W'($urandom);
        it.read_vertex   = VTX_W'($urandom);
        return it;
    endfunction

    // Sends one item. The sender works in bursts; between most bursts it drops
    // tvalid for a random gap. Every assignment lands on a falling edge.
    task automatic send(input logic [KIND_W-1:0] kind, input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-ITEM_W){1'b0}}, it};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (kind == KIND_QUERY) queries_sent++;
        if (kind == KIND_READ) reads_sent++;
    endtask

    task automatic load_conn(input int idx, input int src, input int dst,
                             input int dep, input int trav);
        item_t it;
        it = any_item();
        it.entry_index = IDX_W'(idx);
        it.from_vertex = VTX_W'(src);
        it.to_vertex   = VTX_W'(dst);
        it.depart_time = TIME_W'(dep);
        it.travel_time = TIME_W'(trav);
        send(KIND_LOAD_CONN, it);
    endtask

    task automatic load_offset(input int idx, input int value);
        item_t it;
        it = any_item();
        it.entry_index  = IDX_W'(idx);
        it.offset_value = OFF_W'(value);
        send(KIND_LOAD_OFF, it);
    endtask

    task automatic load_edge(input int idx, input int target);
        item_t it;
        it = any_item();
        it.entry_index = IDX_W'(idx);
        it.edge_target = EDGE_W'(target);
        send(KIND_LOAD_EDGE, it);
    endtask

    task automatic query(input int src, input int ready);
        item_t it;
        it = any_item();
        it.source_vertex = VTX_W'(src);
        it.ready_time    = TIME_W'(ready);
        send(KIND_QUERY, it);
    endtask

    task automatic read_arrival(input int v);
        item_t it;
        it = any_item();
        it.read_vertex = VTX_W'(v);
        send(KIND_READ, it);
    endtask

    // Registers change only with the block idle: every reply is in, and a
    // further wait covers a load that produces no reply.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic reg_index, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwdata  <= $urandom;
    endtask

    // Builds a random graph over a few vertices so that walks chain through
    // several connections, then mixes queries, reads and harmless noise.
    // Offsets are loaded for every connection in range and all successor
    // slots below the largest offset are written, so nothing unwritten is read.
    task automatic random_graph();
        int nc;
        int span;
        int tspan;
        int offs;
        int top_off;
        int v;
        int pick;
        nc    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
        span  = $urandom_range(2, 10);
        tspan = ($urandom_range(0, 3) == 0) ? 30'h3FFF_FFFF : $urandom_range(20, 200);
        settle();
        case ($urandom_range(0, 5))
            0: write_reg(REG_VERTEX_COUNT, 511);
            1: write_reg(REG_VERTEX_COUNT, $urandom_range(1, 8));
            default: write_reg(REG_VERTEX_COUNT, $urandom_range(1, 256));
        endcase
        write_reg(REG_CONN_COUNT, nc);
        for (int c = 0; c < nc; c++) begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span-1);
            load_conn(c, $urandom_range(0, span-1), v, $urandom_range(0, tspan),
                      $urandom_range(0, tspan / 4 + 1));
        end
        offs = 0;
        top_off = 0;
        for (int c = 0; c <= nc; c++) begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, offs) : offs;
            load_offset(c, v);
            if (v > top_off) top_off = v;
            offs += $urandom_range(0, 3);
        end
        for (int k = 0; k < top_off; k++)
            load_edge(k, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, nc));
        repeat ($urandom_range(8, 20)) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span-1);
                query(v, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, tspan / 2));
            end else if (pick < 8) begin
                read_arrival(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, span-1));
            end else begin
                case ($urandom_range(0, 4))
                    0: send(KIND_t'($urandom_range(5, 7)), any_item());
                    1: load_conn($urandom_range(1024, 4095), $urandom, $urandom, $urandom,
                                 $urandom);
                    2: load_offset($urandom_range(1025, 4095), $urandom);
                    3: load_offset(1024, $urandom);
                    default: if (nc > 0)
                        load_conn($urandom_range(0, nc-1), $urandom_range(0, span-1),
                                  $urandom_range(0, span-1), $urandom_range(0, tspan),
                                  $urandom_range(0, tspan / 4 + 1));
                endcase
            end
        end
        graphs_built++;
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_LOAD_CONN;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        items_sent = 0;
        queries_sent = 0;
        reads_sent = 0;
        graphs_built = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // The block clears its memories after reset; wait until it takes items.
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        // Directed graph. From vertex 0 at time 10 the seeds are connection 3,
        // then those leaving at 20 and 10; the one at 20 reaches vertex 2 first at
        // 21, then the chain through vertex 1 improves it to 18. Connection 3 has the
        // largest departure and travel, giving the largest possible arrival.
        write_reg(REG_VERTEX_COUNT, 256);
        write_reg(REG_CONN_COUNT, 4);
        load_conn(0, 0, 1, 10, 5);
        load_conn(1, 0, 2, 20, 1);
        load_conn(2, 1, 2, 16, 2);
        load_conn(3, 0, 255, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
        load_offset(0, 0);
        load_offset(1, 1);
        load_offset(2, 1);
        load_offset(3, 2);
        load_offset(4, 2);
        load_edge(0, 2);
        load_edge(1, 5);              // successor beyond the connection count
        load_edge(4095, 1023);        // highest slot, never inside a range
        load_offset(1024, 8191);      // last offset slot, every bit set
        load_conn(4095, 255, 255, 30'h3FFF_FFFF, 30'h3FFF_FFFF); // ignored
        load_offset(4095, 8191);      // ignored
        send(KIND_t'(5), any_item());
        send(KIND_t'(7), any_item());
        query(0, 10);
        read_arrival(1);
        read_arrival(2);
        read_arrival(255);
        read_arrival(7);              // never reached
        query(0, 30'h3FFF_FFFF);      // only the late connection qualifies
        read_arrival(255);
        query(255, 0);                // source with no departures
        // Shrinking the vertex count leaves higher vertices stale.
        settle();
        write_reg(REG_VERTEX_COUNT, 1);
        query(1, 3);
        read_arrival(2);
        read_arrival(1);
        settle();
        write_reg(REG_CONN_COUNT, 0);
        query(0, 0);
        read_arrival(1);

        repeat (14) random_graph();

        settle();
        $display("Covered %0d items (%0d queries, %0d arrival reads) over %0d graphs,",
                 items_sent, queries_sent, reads_sent, graphs_built + 1);
        $display("including saturated and minimal register settings and a long result stall.");
        if (mismatches == 0 && replies_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/tea_pkg.sv
src/tea_ram.sv
src/temporal_earliest_arrival_bfs.sv
verif/tea_checker.sv
verif/testbench.sv
